>>> hdl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
package lpht_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned SlotW      = $clog2(TableDepth);
  localparam int unsigned CountW     = SlotW + 1;
  localparam int unsigned KeyW       = 48;
  localparam int unsigned CfgW       = 11;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_e;

  // Classified request handed from front to back.
  typedef struct packed {
    req_e              kind;
    logic [KeyW-1:0]   key;
    logic [SlotW-1:0]  home;
    logic [CountW-1:0] n;
  } job_t;

endpackage

>>> hdl/lpht_front.sv
// Front end: takes request beats and reduces the key modulo the slot count.
module lpht_front import lpht_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CfgW-1:0]   slots_in_use_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [KeyW-1:0]   key_i,
  output logic              job_valid_o,
  input  logic              job_stall_i,
  output job_t              job_o
);

  // Restoring remainder, one key bit per cycle.
  localparam int unsigned BitCntW = $clog2(KeyW + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [BitCntW-1:0]  cnt_q, cnt_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [KeyW-1:0]     shf_q, shf_d;
  logic [CountW:0]     rem_q, rem_d;
  logic [CountW-1:0]   n_q, n_d;
  req_e                kind_q, kind_d;
  logic [CountW-1:0]   n_eff;
  logic [CountW:0]     trial;

  always_comb begin
    if (slots_in_use_i == '0) begin
      n_eff = CountW'(1);
    end else if (CfgW'(slots_in_use_i) > CfgW'(TableDepth)) begin
      n_eff = CountW'(TableDepth);
    end else begin
      n_eff = CountW'(slots_in_use_i);
    end
  end

  assign trial = {rem_q[CountW-1:0], shf_q[KeyW-1]};
  assign in_stall_o = busy_q | done_q;
  assign job_valid_o = done_q;
  assign job_o = '{kind: kind_q, key: key_q, home: rem_q[SlotW-1:0], n: n_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    key_d  = key_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    n_d    = n_q;
    kind_d = kind_q;
    if (!busy_q && !done_q && in_valid_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      key_d  = key_i;
      shf_d  = key_i;
      rem_d  = '0;
      n_d    = n_eff;
      kind_d = req_e'(req_type_i);
    end else if (busy_q) begin
      shf_d = {shf_q[KeyW-2:0], 1'b0};
      rem_d = (trial >= {1'b0, n_q}) ? trial - {1'b0, n_q} : trial;
      cnt_d = cnt_q + BitCntW'(1);
      if (cnt_q == BitCntW'(KeyW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q && !job_stall_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    shf_q  <= shf_d;
    rem_q  <= rem_d;
    n_q    <= n_d;
    kind_q <= kind_d;
  end

endmodule

>>> hdl/lpht_queue.sv
// Short job queue between the front and back ends.
module lpht_queue import lpht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_stall_o,
  input  job_t push_i,
  output logic pop_valid_o,
  input  logic pop_stall_i,
  output job_t pop_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign push_stall_o = (cnt_q == (PtrW+1)'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = mem_q[rd_q];
  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_valid_o && !pop_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PtrW'(1);
      if (pop)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_i;
  end

endmodule

>>> hdl/lpht_back.sv
// Back end: probe sequencer over the key and mark memories, plus result register.
module lpht_back import lpht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_stall_o,
  input  job_t             job_i,
  output logic             clr_busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [SlotW-1:0] slot_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [KeyW-1:0]   keys_q  [TableDepth];
  mark_e             marks_q [TableDepth];
  logic [KeyW-1:0]   rkey_q;
  mark_e             rmark_q;
  job_t              job_q, job_d;
  logic [SlotW-1:0]  pos_q, pos_d;
  logic [CountW-1:0] step_q, step_d;
  logic [SlotW-1:0]  clr_q, clr_d;
  status_e           st_q, st_d;
  logic [SlotW-1:0]  res_q, res_d;
  logic              kwe, mwe;
  logic [SlotW-1:0]  waddr;
  mark_e             wmark;
  logic [SlotW-1:0]  next_pos;

  assign job_stall_o = (state_q != S_IDLE);
  assign clr_busy_o  = (state_q == S_CLEAR);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = st_q;
  assign slot_o      = res_q;
  assign next_pos = ((CountW'(pos_q) + CountW'(1)) == job_q.n) ? '0 : pos_q + SlotW'(1);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    pos_d   = pos_q;
    step_d  = step_q;
    clr_d   = clr_q;
    st_d    = st_q;
    res_d   = res_q;
    kwe     = 1'b0;
    mwe     = 1'b0;
    waddr   = pos_q;
    wmark   = MARK_USED;
    case (state_q)
      S_CLEAR: begin
        mwe   = 1'b1;
        waddr = clr_q;
        wmark = MARK_EMPTY;
        clr_d = clr_q + SlotW'(1);
        if (clr_q == SlotW'(TableDepth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (job_valid_i) begin
          job_d  = job_i;
          pos_d  = job_i.home;
          step_d = '0;
          if (job_i.kind == REQ_NONE) begin
            st_d    = ST_NOTFOUND;
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        state_d = S_READ;
        if (job_q.kind == REQ_INSERT) begin
          if (rmark_q != MARK_USED) begin
            kwe = 1'b1; mwe = 1'b1; wmark = MARK_USED;
            st_d = ST_DONE; res_d = pos_q; state_d = S_OUT;
          end
        end else if (rmark_q == MARK_USED && rkey_q == job_q.key) begin
          if (job_q.kind == REQ_REMOVE) begin
            mwe = 1'b1; wmark = MARK_TOMB;
          end
          st_d = ST_DONE; res_d = pos_q; state_d = S_OUT;
        end else if (rmark_q == MARK_EMPTY) begin
          st_d = ST_NOTFOUND; res_d = '0; state_d = S_OUT;
        end
        if (state_d == S_READ) begin
          if (step_q + CountW'(1) == job_q.n) begin
            st_d    = (job_q.kind == REQ_INSERT) ? ST_FULL : ST_NOTFOUND;
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            step_d = step_q + CountW'(1);
            pos_d  = next_pos;
          end
        end
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    pos_q  <= pos_d;
    step_q <= step_d;
    st_q   <= st_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (kwe) keys_q[waddr] <= job_q.key;
    rkey_q <= keys_q[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (mwe) marks_q[waddr] <= wmark;
    rmark_q <= marks_q[pos_q];
  end

endmodule

>>> hdl/linear_probe_hash_table.sv
// Top level of the linear probing hash table.
//   channel  | handshake                   | payload
//   request  | in_valid_i / in_stall_o     | req_type_i, key_i
//   result   | out_valid_o / out_stall_i   | status_o, slot_o
//   config   | slots_in_use_we_i           | slots_in_use_i
// A request passes through the bit-serial modulo, a hand-off through the front output and
// the queue, then a memory read and a compare per probe, and the result register.
// The front may reduce the next key while the back probes; a 2-entry queue sits between.
// After reset the back sweeps the mark memory before taking work.
// Results hold while out_stall_i is high.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             slots_in_use_we_i,
  input  logic [CfgW-1:0]  slots_in_use_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       req_type_i,
  input  logic [KeyW-1:0]  key_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [SlotW-1:0] slot_o
);

  logic [CfgW-1:0] cfg_q;
  logic fr_valid, fr_stall, bk_valid, bk_stall, clr_busy, fr_in_stall;
  job_t fr_job, bk_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= CfgW'(1024);
    else if (slots_in_use_we_i) cfg_q <= slots_in_use_i;
  end

  assign in_stall_o = fr_in_stall | clr_busy;

  lpht_front u_front (
    .clk_i, .rst_ni,
    .slots_in_use_i(cfg_q),
    .in_valid_i(in_valid_i & ~clr_busy),
    .in_stall_o(fr_in_stall),
    .req_type_i, .key_i,
    .job_valid_o(fr_valid), .job_stall_i(fr_stall), .job_o(fr_job)
  );

  lpht_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fr_valid), .push_stall_o(fr_stall), .push_i(fr_job),
    .pop_valid_o(bk_valid), .pop_stall_i(bk_stall), .pop_o(bk_job)
  );

  lpht_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bk_valid), .job_stall_o(bk_stall), .job_i(bk_job),
    .clr_busy_o(clr_busy),
    .out_valid_o, .out_stall_i, .status_o, .slot_o
  );

endmodule

>>> hdl/lpht_checker.sv
// Port-level checks for the hash table, bound to the top level.
module lpht_checker import lpht_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       status_o,
  input logic [SlotW-1:0] slot_o
);

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> slot_o == '0) else $error("slot not zero");
  a_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != ST_RSVD) else $error("bad status");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(slot_o))
    else $error("result beat dropped");
  a_reset_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o) else $error("request taken during clear");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .status_o, .slot_o
);
